/* rtl/jsym_pkg.sv */
`default_nettype none

package jsym_pkg;

    localparam int WORD_BITS = 64;
    localparam int IDX_W     = 2;
    localparam int S_DATA_W  = 72;
    localparam int M_DATA_W  = 8;

    localparam logic [2:0] MOD8_MASK = 3'h7;
    localparam logic [2:0] RES_THREE = 3'd3;
    localparam logic [2:0] RES_FIVE  = 3'd5;
    localparam logic [1:0] MOD4_THREE = 2'd3;

    localparam logic signed [1:0] SYM_POS  = 2'sb01;
    localparam logic signed [1:0] SYM_NEG  = 2'sb11;
    localparam logic signed [1:0] SYM_ZERO = 2'sb00;

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOAD,
        S_RUN,
        S_DONE
    } t_state;

    typedef struct packed {
        logic store;
        logic load;
        logic step;
        logic capture;
    } t_cmd;

    typedef struct packed {
        logic bad;
        logic n_zero;
    } t_status;

endpackage

`default_nettype wire

/* rtl/jsym_ctrl.sv */
`default_nettype none

module jsym_ctrl
    import jsym_pkg::*;
(
    input  wire     i_clk,
    input  wire     i_rst_n,
    input  wire     i_s_valid,
    input  wire     i_compute,
    input  wire     i_m_ready,
    input  t_status i_status,
    output logic    o_s_ready,
    output logic    o_m_valid,
    output t_cmd    o_cmd
);

    t_state r_state, n_state;
    logic   r_m_valid, n_m_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_m_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_m_valid <= n_m_valid;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_s_ready   = 1'b0;
        n_m_valid   = r_m_valid && !i_m_ready;
        unique case (r_state)
            S_IDLE: begin
                o_s_ready = 1'b1;
                if (i_s_valid) begin
                    o_cmd.store = 1'b1;
                    if (i_compute) begin
                        n_state = S_LOAD;
                    end
                end
            end
            S_LOAD: begin
                o_cmd.load = 1'b1;
                n_state    = S_RUN;
            end
            S_RUN: begin
                if (i_status.bad || i_status.n_zero) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.step = 1'b1;
                end
            end
            S_DONE: begin
                if (!r_m_valid || i_m_ready) begin
                    o_cmd.capture = 1'b1;
                    n_m_valid     = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_m_valid = r_m_valid;

endmodule

`default_nettype wire

/* rtl/jsym_datapath.sv */
`default_nettype none

module jsym_datapath
    import jsym_pkg::*;
#(
    parameter int OPERAND_BITS = 256,
    parameter int WORD_COUNT   = 4
) (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  t_cmd                   i_cmd,
    input  wire                    i_wr_sel,
    input  wire [IDX_W-1:0]        i_wr_idx,
    input  wire [WORD_BITS-1:0]    i_wr_val,
    output t_status                o_status,
    output logic signed [1:0]      o_symbol,
    output logic                   o_bad_modulus
);

    localparam int W        = WORD_BITS * WORD_COUNT;
    localparam int TOP_BITS = OPERAND_BITS - WORD_BITS * (WORD_COUNT - 1);
    localparam logic [WORD_BITS-1:0] TOP_MASK =
        (TOP_BITS >= WORD_BITS) ? {WORD_BITS{1'b1}} :
        (TOP_BITS <= 0)         ? {WORD_BITS{1'b0}} :
                                  ((WORD_BITS'(1) << TOP_BITS) - WORD_BITS'(1));

    logic [WORD_BITS-1:0] r_value   [WORD_COUNT];
    logic [WORD_BITS-1:0] r_modulus [WORD_COUNT];
    logic [W-1:0]         value_flat, modulus_flat;

    logic [W-1:0]         r_n, r_k;
    logic                 r_sign;
    logic                 r_bad;

    logic [W:0]           diff;
    logic                 n_lt_k;
    logic [2:0]           k_mod8;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < WORD_COUNT; i++) begin
                r_value[i]   <= '0;
                r_modulus[i] <= '0;
            end
        end else if (i_cmd.store) begin
            for (int i = 0; i < WORD_COUNT; i++) begin
                if (32'(i_wr_idx) == i) begin
                    if (i_wr_sel) begin
                        r_modulus[i] <= (i == WORD_COUNT - 1) ? (i_wr_val & TOP_MASK)
                                                               : i_wr_val;
                    end else begin
                        r_value[i] <= (i == WORD_COUNT - 1) ? (i_wr_val & TOP_MASK)
                                                             : i_wr_val;
                    end
                end
            end
        end
    end

    always_comb begin
        for (int i = 0; i < WORD_COUNT; i++) begin
            value_flat[i*WORD_BITS +: WORD_BITS]   = r_value[i];
            modulus_flat[i*WORD_BITS +: WORD_BITS] = r_modulus[i];
        end
    end

    assign diff   = {1'b0, r_n} - {1'b0, r_k};
    assign n_lt_k = diff[W];
    assign k_mod8 = r_k[2:0] & MOD8_MASK;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_n    <= value_flat;
            r_k    <= modulus_flat;
            r_sign <= 1'b0;
            r_bad  <= ~modulus_flat[0];
        end else if (i_cmd.step) begin
            if (!r_n[0]) begin
                r_n <= r_n >> 1;
                if (k_mod8 == RES_THREE || k_mod8 == RES_FIVE) begin
                    r_sign <= ~r_sign;
                end
            end else if (n_lt_k) begin
                r_n <= r_k;
                r_k <= r_n;
                if (r_n[1:0] == MOD4_THREE && r_k[1:0] == MOD4_THREE) begin
                    r_sign <= ~r_sign;
                end
            end else begin
                r_n <= diff[W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            o_bad_modulus <= r_bad;
            if (r_bad || r_k != W'(1)) begin
                o_symbol <= SYM_ZERO;
            end else begin
                o_symbol <= r_sign ? SYM_NEG : SYM_POS;
            end
        end
    end

    assign o_status.bad    = r_bad;
    assign o_status.n_zero = ~|r_n;

endmodule

`default_nettype wire

/* rtl/jacobi_symbol_256.sv */
`default_nettype none

// Jacobi symbol unit using the binary method. Each input item stores one
// 64-bit word of the value n or the odd modulus k, and an item with the
// compute flag set then evaluates (n/k) from both stores, which reset to zero.
// While a computation runs the input is not ready; a finished result waits in
// the output register, and the input takes new items meanwhile. The
// evaluation loop does one step per cycle with a single full-width
// subtractor: a halving of n, a swap, or a subtraction. A computation passes
// through the accept, a load, the loop steps, a final check and the capture
// of the result, which waits while the output register holds a result not
// yet taken. Every halving drops one bit of n or k, every subtraction leaves
// n even and every swap is followed by a subtraction, so the loop needs at
// most three steps for each bit of n and k together, and the step count
// depends on the data. An even or zero modulus finishes without loop steps,
// with bad_modulus set and a symbol of zero.
module jacobi_symbol_256
    import jsym_pkg::*;
#(
    parameter int OPERAND_BITS = 256,
    parameter int WORD_COUNT   = 4
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_s_axis_tvalid,
    output logic                 o_s_axis_tready,
    // word_index [1:0], word_value [65:2], compute_now [66], zero pad [71:67]
    input  wire [S_DATA_W-1:0]   i_s_axis_tdata,
    // operand_select [0]
    input  wire                  i_s_axis_tuser,
    output logic                 o_m_axis_tvalid,
    input  wire                  i_m_axis_tready,
    // symbol [1:0], bad_modulus [2], zero pad [7:3]
    output logic [M_DATA_W-1:0]  o_m_axis_tdata
);

    t_cmd              cmd;
    t_status           status;
    logic signed [1:0] symbol;
    logic              bad_modulus;
    logic              compute_now;

    assign compute_now = i_s_axis_tdata[66];

    jsym_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (i_s_axis_tvalid),
        .i_compute (compute_now),
        .i_m_ready (i_m_axis_tready),
        .i_status  (status),
        .o_s_ready (o_s_axis_tready),
        .o_m_valid (o_m_axis_tvalid),
        .o_cmd     (cmd)
    );

    jsym_datapath #(
        .OPERAND_BITS (OPERAND_BITS),
        .WORD_COUNT   (WORD_COUNT)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_wr_sel      (i_s_axis_tuser),
        .i_wr_idx      (i_s_axis_tdata[1:0]),
        .i_wr_val      (i_s_axis_tdata[65:2]),
        .o_status      (status),
        .o_symbol      (symbol),
        .o_bad_modulus (bad_modulus)
    );

    assign o_m_axis_tdata = {5'd0, bad_modulus, symbol};

    a_capture_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.capture |=> o_m_axis_tvalid)
        else $error("result register not valid after capture");

    a_busy_after_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready && compute_now) |=> !o_s_axis_tready)
        else $error("input ready while a computation starts");

    a_symbol_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (o_m_axis_tdata[1:0] != 2'b10))
        else $error("symbol outside -1, 0, 1");

    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tdata[2]) |-> (o_m_axis_tdata[1:0] == 2'b00))
        else $error("bad modulus with nonzero symbol");

endmodule

`default_nettype wire

/* tb/sv/jacobi_symbol_256_tb.sv */
`timescale 1ns / 100ps

module jacobi_symbol_256_tb;
    import jsym_pkg::*;

    localparam int OP_BITS     = 256;
    localparam int OP_WORDS    = 4;
    localparam int ITEM_TARGET = 550;
    localparam int LONG_HOLD   = 4000;
    localparam int TAIL_CYCLES = 1000;
    localparam int CYCLE_LIMIT = 2_000_000;

    typedef struct packed {
        logic              bad;
        logic signed [1:0] symbol;
    } symbol_t;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_s_axis_tvalid = 1'b0;
    logic                o_s_axis_tready;
    logic [S_DATA_W-1:0] i_s_axis_tdata = '0;
    logic                i_s_axis_tuser = 1'b0;
    logic                o_m_axis_tvalid;
    logic                i_m_axis_tready = 1'b0;
    logic [M_DATA_W-1:0] o_m_axis_tdata;

    logic [OP_BITS-1:0] value_n = '0;
    logic [OP_BITS-1:0] modulus_k = '0;
    symbol_t            symbols_due[$];

    int  gap_ahead = 1;
    bit  burst_mode = 1'b0;
    bit  out_fire = 1'b0;
    int  stall_left = 0;
    int  hold_left = 0;
    int  hold_requests = 0;
    int  hold_served = 0;

    int  fail_count = 0;
    int  items_sent = 0;
    int  results_checked = 0;
    int  count_neg = 0;
    int  count_zero = 0;
    int  count_pos = 0;
    int  count_bad = 0;

    jacobi_symbol_256 dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("[FAIL] regression broken");
        $finish;
    end

    function automatic symbol_t jacobi_binary(input logic [OP_BITS-1:0] n_in,
                                              input logic [OP_BITS-1:0] k_in);
        logic [OP_BITS-1:0] n;
        logic [OP_BITS-1:0] k;
        logic [OP_BITS-1:0] t;
        logic [2:0]         r8;
        logic               flip;
        symbol_t            res;
        n = n_in;
        k = k_in;
        flip = 1'b0;
        res.bad = 1'b0;
        res.symbol = SYM_ZERO;
        if (k == '0 || !k[0]) begin
            res.bad = 1'b1;
            return res;
        end
        while (n != '0) begin
            while (!n[0]) begin
                r8 = k[2:0] & MOD8_MASK;
                if (r8 == RES_THREE || r8 == RES_FIVE) begin
                    flip = ~flip;
                end
                n = n >> 1;
            end
            if (n < k) begin
                if (n[1:0] == MOD4_THREE && k[1:0] == MOD4_THREE) begin
                    flip = ~flip;
                end
                t = n;
                n = k;
                k = t;
            end
            n = n - k;
        end
        if (k == OP_BITS'(1)) begin
            res.symbol = flip ? SYM_NEG : SYM_POS;
        end
        return res;
    endfunction

    function automatic logic [OP_BITS-1:0] random_operand(input int words);
        logic [OP_BITS-1:0] r;
        r = '0;
        for (int i = 0; i < words; i++) begin
            r[i*64 +: 64] = {$urandom, $urandom};
        end
        if ($urandom_range(0, 1) == 1) begin
            r[(words-1)*64 +: 64] = r[(words-1)*64 +: 64] >> $urandom_range(0, 63);
        end
        return r;
    endfunction

    // Valid stays high across back-to-back items; it is only lowered when a gap follows.
    task automatic send_word(input logic sel, input logic [1:0] idx,
                             input logic [63:0] val, input logic go);
        logic ready_seen;
        repeat (gap_ahead) @(posedge i_clk);
        i_s_axis_tdata <= {5'b0, go, val, idx};
        i_s_axis_tuser <= sel;
        if (gap_ahead != 0) begin
            i_s_axis_tvalid <= 1'b1;
        end
        do begin
            @(negedge i_clk);
            ready_seen = o_s_axis_tready;
            @(posedge i_clk);
        end while (!ready_seen);
        if (sel) begin
            modulus_k[idx*64 +: 64] = val;
        end else begin
            value_n[idx*64 +: 64] = val;
        end
        if (go) begin
            symbols_due.push_back(jacobi_binary(value_n, modulus_k));
        end
        items_sent++;
        gap_ahead = burst_mode ? 0 : $urandom_range(0, 8);
        if (gap_ahead != 0) begin
            i_s_axis_tvalid <= 1'b0;
        end
    endtask

    task automatic stop_stream();
        if (gap_ahead == 0) begin
            i_s_axis_tvalid <= 1'b0;
            gap_ahead = 1;
        end
    endtask

    task automatic drain_results();
        stop_stream();
        while (symbols_due.size() != 0) @(posedge i_clk);
    endtask

    task automatic send_operand_set();
        logic [OP_BITS-1:0] n;
        logic [OP_BITS-1:0] k;
        int                 pick;
        bit                 n_first;
        k = random_operand($urandom_range(1, OP_WORDS));
        pick = $urandom_range(0, 19);
        if (pick == 0) begin
            k = '0;
        end else if (pick <= 2) begin
            k[0] = 1'b0;
        end else begin
            k[0] = 1'b1;
        end
        case ($urandom_range(0, 9))
            0: n = '0;
            1: n = k;
            2: n = k * OP_BITS'($urandom_range(2, 9));
            default: n = random_operand($urandom_range(1, OP_WORDS));
        endcase
        n_first = 1'($urandom_range(0, 1));
        for (int i = 0; i < OP_WORDS; i++) begin
            if (n_first) begin
                send_word(1'b0, i[1:0], n[i*64 +: 64], 1'b0);
            end else begin
                send_word(1'b1, i[1:0], k[i*64 +: 64], 1'b0);
            end
        end
        for (int i = 0; i < OP_WORDS; i++) begin
            if (n_first) begin
                send_word(1'b1, i[1:0], k[i*64 +: 64], i == OP_WORDS - 1);
            end else begin
                send_word(1'b0, i[1:0], n[i*64 +: 64], i == OP_WORDS - 1);
            end
        end
    endtask

    task automatic test_directed_edges();
        send_word(1'b0, 2'd0, 64'd0, 1'b1);
        send_word(1'b1, 2'd0, 64'd1, 1'b1);
        send_word(1'b1, 2'd0, 64'd2, 1'b1);
        send_word(1'b1, 2'd0, 64'd7, 1'b1);
        send_word(1'b0, 2'd0, 64'd2, 1'b1);
        send_word(1'b1, 2'd0, 64'd3, 1'b1);
        send_word(1'b0, 2'd0, 64'd3, 1'b1);
        for (int i = 0; i < OP_WORDS; i++) begin
            send_word(1'b0, i[1:0], '1, i == OP_WORDS - 1);
        end
        for (int i = 0; i < OP_WORDS; i++) begin
            send_word(1'b1, i[1:0], '1, i == OP_WORDS - 1);
        end
        send_word(1'b0, 2'd3, 64'h8000_0000_0000_0000, 1'b1);
        send_word(1'b1, 2'd0, 64'hFFFF_FFFF_FFFF_FFFE, 1'b1);
        send_word(1'b1, 2'd0, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1);
        send_word(1'b0, 2'd3, 64'd0, 1'b1);
    endtask

    // The receiver stops for a long stretch while compute items keep coming.
    task automatic test_back_pressure();
        logic [63:0] word;
        drain_results();
        hold_requests <= hold_requests + 1;
        for (int i = 0; i < 6; i++) begin
            word = {$urandom, $urandom};
            if (i[0]) begin
                word[0] = 1'b1;
            end
            send_word(i[0], 2'd0, word, 1'b1);
        end
        drain_results();
    endtask

    task automatic test_random_operands();
        int          pick;
        int          writes;
        logic        sel;
        logic [1:0]  idx;
        logic [63:0] word;
        while (items_sent < ITEM_TARGET) begin
            if ($urandom_range(0, 11) == 0) begin
                burst_mode <= ~burst_mode;
            end
            pick = $urandom_range(0, 9);
            if (pick < 6) begin
                send_operand_set();
            end else if (pick < 8) begin
                writes = $urandom_range(1, 2);
                for (int i = 0; i < writes; i++) begin
                    sel = 1'($urandom_range(0, 1));
                    idx = 2'($urandom_range(0, 3));
                    word = {$urandom, $urandom};
                    if (sel && idx == 2'd0) begin
                        word[0] = ($urandom_range(0, 5) != 0);
                    end
                    send_word(sel, idx, word, i == writes - 1);
                end
            end else begin
                send_word(1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)),
                          {$urandom, $urandom}, $urandom_range(0, 3) == 0);
            end
        end
        burst_mode <= 1'b0;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
            stall_left <= 0;
            hold_left <= 0;
        end else if (hold_served != hold_requests) begin
            hold_served <= hold_requests;
            hold_left <= LONG_HOLD;
            i_m_axis_tready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (out_fire) begin
            int draw;
            draw = burst_mode ? 0 : $urandom_range(0, 8);
            if (draw != 0) begin
                i_m_axis_tready <= 1'b0;
                stall_left <= draw - 1;
            end
        end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
        end else begin
            i_m_axis_tready <= 1'b1;
        end
    end

    // Outputs are sampled at the falling edge ahead of the rising edge that transfers them.
    always @(negedge i_clk) begin
        symbol_t got;
        symbol_t want;
        out_fire = 1'b0;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            out_fire = 1'b1;
            got.symbol = o_m_axis_tdata[1:0];
            got.bad = o_m_axis_tdata[2];
            if (symbols_due.size() == 0) begin
                $error("unexpected result item, tdata %h", o_m_axis_tdata);
                fail_count++;
            end else begin
                want = symbols_due.pop_front();
                results_checked++;
                if (want.bad) begin
                    count_bad++;
                end else if (want.symbol == SYM_NEG) begin
                    count_neg++;
                end else if (want.symbol == SYM_POS) begin
                    count_pos++;
                end else begin
                    count_zero++;
                end
                if (got.symbol !== want.symbol) begin
                    $error("symbol: expected %0d, got %0d", want.symbol, got.symbol);
                    fail_count++;
                end
                if (got.bad !== want.bad) begin
                    $error("bad_modulus: expected %0b, got %0b", want.bad, got.bad);
                    fail_count++;
                end
            end
        end
    end

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed_edges();
        test_back_pressure();
        test_random_operands();
        drain_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        $display("Sent %0d items and checked %0d Jacobi results.", items_sent, results_checked);
        $display("Symbols seen: %0d of -1, %0d of 0, %0d of +1, %0d with a bad modulus.",
                 count_neg, count_zero, count_pos, count_bad);
        if (fail_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
